FILE: hdl/point_clip_cull_decimator_defines.svh
// Assertion macros shared by the point clip, cull and decimate design.
`ifndef POINT_CLIP_CULL_DECIMATOR_DEFINES_SVH
`define POINT_CLIP_CULL_DECIMATOR_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PCC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PCC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hdl/pcc_pkg.sv
// Types and constants of the point clip, cull and decimate block.
package pcc_pkg;

  localparam int CFG_CNT_W  = 25;  // max_count and stride registers
  localparam int CFG_ROW_W  = 64;  // one matrix row
  localparam int CFG_DATA_W = 64;  // widest register
  localparam int CFG_IDX_W  = 3;   // register index
  localparam int POS_FRAC   = 12;  // fraction bits of a position

  typedef enum logic [1:0] {
    MODE_KEEP_ALL   = 2'd0,
    MODE_KEEP_FIRST = 2'd1,
    MODE_STRIDE     = 2'd2
  } pcc_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECIMATE_MODE = 3'd0,
    REG_CULL_ENABLE   = 3'd1,
    REG_MAX_COUNT     = 3'd2,
    REG_STRIDE        = 3'd3,
    REG_MATRIX_ROW0   = 3'd4,
    REG_MATRIX_ROW1   = 3'd5,
    REG_MATRIX_ROW2   = 3'd6,
    REG_MATRIX_ROW3   = 3'd7
  } pcc_reg_e;

  typedef struct packed {
    pcc_mode_e                       mode;
    logic                            cull_en;
    logic [CFG_CNT_W-1:0]            max_count;
    logic [CFG_CNT_W-1:0]            stride;
    logic [3:0][CFG_ROW_W-1:0]       rows;
  } pcc_cfg_t;

endpackage

FILE: hdl/pcc_decim.sv
// Point indexing, decimation and the input register.
`include "point_clip_cull_decimator_defines.svh"

module pcc_decim #(
  parameter int POS_WIDTH   = 24,
  parameter int INDEX_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pcc_pkg::pcc_cfg_t             cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [POS_WIDTH-1:0]   in_x_i,
  input  logic signed [POS_WIDTH-1:0]   in_y_i,
  input  logic signed [POS_WIDTH-1:0]   in_z_i,
  input  logic                          in_first_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [POS_WIDTH-1:0]   out_x_o,
  output logic signed [POS_WIDTH-1:0]   out_y_o,
  output logic signed [POS_WIDTH-1:0]   out_z_o,
  output logic [INDEX_WIDTH-1:0]        out_idx_o
);
  import pcc_pkg::*;

  localparam int CMP_W = (INDEX_WIDTH + 1 > CFG_CNT_W) ? INDEX_WIDTH + 1 : CFG_CNT_W;

  logic [INDEX_WIDTH-1:0] cnt_q, cnt_d;
  logic [INDEX_WIDTH-1:0] phase_q, phase_d;
  logic [INDEX_WIDTH-1:0] idx, phase;
  logic [CFG_CNT_W-1:0]   max_eff, stride_eff;
  logic [CMP_W-1:0]       phase_nx;
  logic                   accept, keep;

  logic                          valid_q;
  logic signed [POS_WIDTH-1:0]   x_q, y_q, z_q;
  logic [INDEX_WIDTH-1:0]        idx_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    idx        = in_first_i ? '0 : cnt_q;
    phase      = in_first_i ? '0 : phase_q;
    max_eff    = (cfg_i.max_count == '0) ? CFG_CNT_W'(1) : cfg_i.max_count;
    stride_eff = (cfg_i.stride == '0) ? CFG_CNT_W'(1) : cfg_i.stride;

    // Advance the counters on every point, kept or not.
    cnt_d    = idx + INDEX_WIDTH'(1);
    phase_nx = CMP_W'(phase) + CMP_W'(1);
    if (phase_nx >= CMP_W'(stride_eff) || phase_nx[INDEX_WIDTH]) begin
      phase_d = '0;
    end else begin
      phase_d = phase_nx[INDEX_WIDTH-1:0];
    end

    unique case (cfg_i.mode)
      MODE_KEEP_FIRST: keep = CMP_W'(idx) < CMP_W'(max_eff);
      MODE_STRIDE:     keep = (phase == '0);
      default:         keep = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      phase_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q   <= cnt_d;
        phase_q <= phase_d;
      end
      if (in_ready_o) begin
        valid_q <= accept && keep;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q   <= in_x_i;
      y_q   <= in_y_i;
      z_q   <= in_z_i;
      idx_q <= idx;
    end
  end

  assign out_valid_o = valid_q;
  assign out_x_o     = x_q;
  assign out_y_o     = y_q;
  assign out_z_o     = z_q;
  assign out_idx_o   = idx_q;

  `PCC_ASSERT(a_first_restarts_index, (accept && in_first_i) |=> (cnt_q == INDEX_WIDTH'(1)), "first point did not restart the index")
  `PCC_ASSERT(a_keep_all_passes, (accept && (cfg_i.mode == MODE_KEEP_ALL)) |=> valid_q, "point lost in keep-all mode")
  `PCC_ASSERT(a_past_max_dropped, (accept && (cfg_i.mode == MODE_KEEP_FIRST) && !in_first_i && (CMP_W'(cnt_q) >= CMP_W'(max_eff))) |=> !valid_q, "point past max_count kept")

endmodule

FILE: hdl/pcc_xform.sv
// Clip-space transform: product stage and row-sum stage.
module pcc_xform #(
  parameter int POS_WIDTH   = 24,
  parameter int COEF_WIDTH  = 16,
  parameter int INDEX_WIDTH = 24,
  parameter int SUM_W       = 42
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pcc_pkg::pcc_cfg_t             cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [POS_WIDTH-1:0]   in_x_i,
  input  logic signed [POS_WIDTH-1:0]   in_y_i,
  input  logic signed [POS_WIDTH-1:0]   in_z_i,
  input  logic [INDEX_WIDTH-1:0]        in_idx_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [POS_WIDTH-1:0]   out_x_o,
  output logic signed [POS_WIDTH-1:0]   out_y_o,
  output logic signed [POS_WIDTH-1:0]   out_z_o,
  output logic [INDEX_WIDTH-1:0]        out_idx_o,
  output logic [3:0][SUM_W-1:0]         out_sum_o
);
  import pcc_pkg::*;

  localparam int PROD_W  = POS_WIDTH + COEF_WIDTH;
  localparam int TRANS_W = COEF_WIDTH + POS_FRAC;

  logic signed [COEF_WIDTH-1:0] coef [4][4];
  logic signed [POS_WIDTH-1:0]  pos_in [3];
  logic signed [PROD_W-1:0]     prod_d [4][3];
  logic signed [PROD_W-1:0]     prod_q [4][3];
  logic signed [TRANS_W-1:0]    trans_d [4];
  logic signed [TRANS_W-1:0]    trans_q [4];
  logic signed [SUM_W-1:0]      sum_d [4];
  logic [3:0][SUM_W-1:0]        sum_q;

  logic                         vb_q, vc_q, ready_b, ready_c;
  logic signed [POS_WIDTH-1:0]  xb_q, yb_q, zb_q, xc_q, yc_q, zc_q;
  logic [INDEX_WIDTH-1:0]       idxb_q, idxc_q;

  assign ready_c    = !vc_q || out_ready_i;
  assign ready_b    = !vb_q || ready_c;
  assign in_ready_o = ready_b;

  assign pos_in[0] = in_x_i;
  assign pos_in[1] = in_y_i;
  assign pos_in[2] = in_z_i;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        coef[r][c] = $signed(cfg_i.rows[r][c*COEF_WIDTH +: COEF_WIDTH]);
      end
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = PROD_W'(coef[r][c]) * PROD_W'(pos_in[c]);
      end
      // Translation column weighs 1.0 in position format.
      trans_d[r] = TRANS_W'(coef[r][3]) <<< POS_FRAC;
    end
    for (int r = 0; r < 4; r++) begin
      sum_d[r] = SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1])
               + SUM_W'(prod_q[r][2]) + SUM_W'(trans_q[r]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (ready_b) vb_q <= in_valid_i;
      if (ready_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_b && in_valid_i) begin
      prod_q  <= prod_d;
      trans_q <= trans_d;
      xb_q    <= in_x_i;
      yb_q    <= in_y_i;
      zb_q    <= in_z_i;
      idxb_q  <= in_idx_i;
    end
    if (ready_c && vb_q) begin
      for (int r = 0; r < 4; r++) begin
        sum_q[r] <= sum_d[r];
      end
      xc_q   <= xb_q;
      yc_q   <= yb_q;
      zc_q   <= zb_q;
      idxc_q <= idxb_q;
    end
  end

  assign out_valid_o = vc_q;
  assign out_x_o     = xc_q;
  assign out_y_o     = yc_q;
  assign out_z_o     = zc_q;
  assign out_idx_o   = idxc_q;
  assign out_sum_o   = sum_q;

endmodule

FILE: hdl/pcc_cull.sv
// Clip-volume test and the result register.
module pcc_cull #(
  parameter int POS_WIDTH   = 24,
  parameter int INDEX_WIDTH = 24,
  parameter int SUM_W       = 42
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cull_en_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [POS_WIDTH-1:0]   in_x_i,
  input  logic signed [POS_WIDTH-1:0]   in_y_i,
  input  logic signed [POS_WIDTH-1:0]   in_z_i,
  input  logic [INDEX_WIDTH-1:0]        in_idx_i,
  input  logic [3:0][SUM_W-1:0]         in_sum_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [POS_WIDTH-1:0]   out_x_o,
  output logic signed [POS_WIDTH-1:0]   out_y_o,
  output logic signed [POS_WIDTH-1:0]   out_z_o,
  output logic [INDEX_WIDTH-1:0]        out_idx_o
);
  logic [SUM_W-1:0]            mag [4];
  logic                        inside_clip, keep;
  logic                        valid_q;
  logic signed [POS_WIDTH-1:0] x_q, y_q, z_q;
  logic [INDEX_WIDTH-1:0]      idx_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mag[r] = in_sum_i[r][SUM_W-1] ? (~in_sum_i[r] + SUM_W'(1)) : in_sum_i[r];
    end
    // Drop the point when w is zero or any axis lies beyond |w|.
    inside_clip = (mag[3] != '0) && (mag[0] <= mag[3])
               && (mag[1] <= mag[3]) && (mag[2] <= mag[3]);
    keep = !cull_en_i || inside_clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      x_q   <= in_x_i;
      y_q   <= in_y_i;
      z_q   <= in_z_i;
      idx_q <= in_idx_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_x_o     = x_q;
  assign out_y_o     = y_q;
  assign out_z_o     = z_q;
  assign out_idx_o   = idx_q;

endmodule

FILE: hdl/point_clip_cull_decimator.sv
// Top level of the point clip, cull and decimate block.
//
// Point positions (signed Q12.12) stream in one word per cycle when ready, and
// kept points stream out unchanged, tagged with their mesh index; tuser marks
// the first point of a mesh and restarts that index. Decimation keeps all
// points, the leading max_count points, or every stride-th point from index 0
// (software supplies stride = ceil(mesh_size / wanted)); index and stride
// phase advance on every point, kept or dropped. With culling on, a point is
// multiplied by the 4x4 matrix with w = 1 and kept only if clip w is nonzero
// and |x|, |y|, |z| <= |w|; products and sums are exact, so nothing saturates.
// The datapath is a four-register pipeline (input/decimate, products, row
// sums, clip test/result) that takes one word every cycle unless stalled; a
// kept point passes them in order to the master side. Each stage holds
// only while the stage after it is full and stalled, so a result waiting on
// m_axis_tready does not stop new words until the pipeline fills behind it.
// Write the configuration only while the pipeline is empty.
module point_clip_cull_decimator #(
  parameter int POS_WIDTH   = 24,
  parameter int COEF_WIDTH  = 16,
  parameter int INDEX_WIDTH = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration write port
  input  logic                                  cfg_we_i,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [pcc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // Point input
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pos_x, pos_y, pos_z from bit 0 up, zero padded to bytes
  input  logic [((3*POS_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  // first_point
  input  logic                                  s_axis_tuser,
  // Kept point output
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // out_x, out_y, out_z, point_index from bit 0 up, zero padded to bytes
  output logic [((3*POS_WIDTH+INDEX_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
  import pcc_pkg::*;

  localparam int M_TDATA_W = ((3*POS_WIDTH+INDEX_WIDTH+7)/8)*8;
  localparam int PROD_W    = POS_WIDTH + COEF_WIDTH;
  localparam int TRANS_W   = COEF_WIDTH + POS_FRAC;
  localparam int SUM_W     = ((PROD_W > TRANS_W) ? PROD_W : TRANS_W) + 2;

  pcc_cfg_t cfg_q;

  logic signed [POS_WIDTH-1:0] in_x, in_y, in_z;

  logic                        a_valid, a_ready;
  logic signed [POS_WIDTH-1:0] a_x, a_y, a_z;
  logic [INDEX_WIDTH-1:0]      a_idx;

  logic                        c_valid, c_ready;
  logic signed [POS_WIDTH-1:0] c_x, c_y, c_z;
  logic [INDEX_WIDTH-1:0]      c_idx;
  logic [3:0][SUM_W-1:0]       c_sum;

  logic signed [POS_WIDTH-1:0] o_x, o_y, o_z;
  logic [INDEX_WIDTH-1:0]      o_idx;

  // Configuration registers; take a write on every enabled cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= MODE_KEEP_ALL;
      cfg_q.cull_en   <= 1'b0;
      cfg_q.max_count <= CFG_CNT_W'(1);
      cfg_q.stride    <= CFG_CNT_W'(1);
      cfg_q.rows      <= '0;
    end else if (cfg_we_i) begin
      unique case (pcc_reg_e'(cfg_idx_i))
        REG_DECIMATE_MODE: cfg_q.mode      <= pcc_mode_e'(cfg_data_i[1:0]);
        REG_CULL_ENABLE:   cfg_q.cull_en   <= cfg_data_i[0];
        REG_MAX_COUNT:     cfg_q.max_count <= cfg_data_i[CFG_CNT_W-1:0];
        REG_STRIDE:        cfg_q.stride    <= cfg_data_i[CFG_CNT_W-1:0];
        REG_MATRIX_ROW0:   cfg_q.rows[0]   <= cfg_data_i[CFG_ROW_W-1:0];
        REG_MATRIX_ROW1:   cfg_q.rows[1]   <= cfg_data_i[CFG_ROW_W-1:0];
        REG_MATRIX_ROW2:   cfg_q.rows[2]   <= cfg_data_i[CFG_ROW_W-1:0];
        REG_MATRIX_ROW3:   cfg_q.rows[3]   <= cfg_data_i[CFG_ROW_W-1:0];
      endcase
    end
  end

  // Unpack the input word; padding bits are ignored.
  assign in_x = s_axis_tdata[POS_WIDTH-1:0];
  assign in_y = s_axis_tdata[2*POS_WIDTH-1:POS_WIDTH];
  assign in_z = s_axis_tdata[3*POS_WIDTH-1:2*POS_WIDTH];

  pcc_decim #(
    .POS_WIDTH   (POS_WIDTH),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_decim (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_x_i      (in_x),
    .in_y_i      (in_y),
    .in_z_i      (in_z),
    .in_first_i  (s_axis_tuser),
    .out_valid_o (a_valid),
    .out_ready_i (a_ready),
    .out_x_o     (a_x),
    .out_y_o     (a_y),
    .out_z_o     (a_z),
    .out_idx_o   (a_idx)
  );

  pcc_xform #(
    .POS_WIDTH   (POS_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH),
    .INDEX_WIDTH (INDEX_WIDTH),
    .SUM_W       (SUM_W)
  ) u_xform (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (a_valid),
    .in_ready_o  (a_ready),
    .in_x_i      (a_x),
    .in_y_i      (a_y),
    .in_z_i      (a_z),
    .in_idx_i    (a_idx),
    .out_valid_o (c_valid),
    .out_ready_i (c_ready),
    .out_x_o     (c_x),
    .out_y_o     (c_y),
    .out_z_o     (c_z),
    .out_idx_o   (c_idx),
    .out_sum_o   (c_sum)
  );

  pcc_cull #(
    .POS_WIDTH   (POS_WIDTH),
    .INDEX_WIDTH (INDEX_WIDTH),
    .SUM_W       (SUM_W)
  ) u_cull (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cull_en_i   (cfg_q.cull_en),
    .in_valid_i  (c_valid),
    .in_ready_o  (c_ready),
    .in_x_i      (c_x),
    .in_y_i      (c_y),
    .in_z_i      (c_z),
    .in_idx_i    (c_idx),
    .in_sum_i    (c_sum),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_x_o     (o_x),
    .out_y_o     (o_y),
    .out_z_o     (o_z),
    .out_idx_o   (o_idx)
  );

  // Pack the result word, zero padded to whole bytes.
  assign m_axis_tdata = M_TDATA_W'({o_idx, o_z, o_y, o_x});

endmodule
